// ===== design/shbi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbi_pkg
// Types, constants and helpers shared by the shelter heat balance integrator.
// ----------------------------------------------------------------------------
package shbi_pkg;

    localparam int unsigned MAX_SUBSTEP_DEF = 20;
    localparam int KELVIN_Q8  = 69926;
    localparam int SIGMA_Q40  = 62346;
    localparam int RHO_CP     = 1214;
    localparam int TEMP_MAX   = 25600;
    localparam int FLUX_MIN   = -65536;
    localparam int FLUX_MAX   = 65535;

    localparam int RST_U      = 1536;
    localparam int RST_ABS    = 55706;
    localparam int RST_CAPC   = 8736;
    localparam int RST_CAPS   = 0;
    localparam int RST_STEP   = 180;
    localparam int RST_HH     = 1024;
    localparam int RST_CPG    = 282;
    localparam int RST_TEMP   = 3072;

    localparam int TW    = 16;
    localparam int FW    = 17;
    localparam int CIW   = 3;
    localparam int CDW   = 20;
    localparam int NW    = 12;
    localparam int NUMW  = 50;
    localparam int DENW  = 37;

    typedef logic signed [36:0] t_mula;
    typedef logic signed [29:0] t_mulb;
    typedef logic signed [66:0] t_prod;
    typedef logic signed [51:0] t_wide;
    typedef logic signed [50:0] t_num;
    typedef logic signed [35:0] t_diff;
    typedef logic signed [26:0] t_tot;
    typedef logic signed [24:0] t_flx;

    typedef enum logic [CIW-1:0] {
        REG_U    = 3'd0,
        REG_ABS  = 3'd1,
        REG_CAPC = 3'd2,
        REG_CAPS = 3'd3,
        REG_STEP = 3'd4,
        REG_HH   = 3'd5,
        REG_CPG  = 3'd6
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_DN, OP_UC, OP_AC, OP_CAIR, OP_NC, OP_NA, OP_SK1, OP_SK2,
        OP_C1, OP_C2, OP_SG, OP_HS, OP_HO, OP_HI, OP_TOT, OP_TS,
        OP_DTC, OP_IS, OP_DTI, OP_DNET
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
        logic mul;
        logic wb;
        logic div_start;
        logic sub_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last;
        logic out_free;
    } t_sts;

    // round half away from zero, then shift right
    function automatic t_prod shr_rnd(t_prod x, int unsigned s);
        t_prod m;
        t_prod r;
        m = (x < 0) ? -x : x;
        r = (m + (t_prod'(1) <<< (s - 1))) >>> s;
        return (x < 0) ? -r : r;
    endfunction

    function automatic logic signed [TW-1:0] sat_temp(t_wide x);
        if (x > t_wide'(TEMP_MAX)) begin
            return TW'(TEMP_MAX);
        end else if (x < t_wide'(-TEMP_MAX)) begin
            return TW'(-TEMP_MAX);
        end
        return x[TW-1:0];
    endfunction

    function automatic logic signed [FW-1:0] sat_flux(t_wide x);
        if (x > t_wide'(FLUX_MAX)) begin
            return FW'(FLUX_MAX);
        end else if (x < t_wide'(FLUX_MIN)) begin
            return FW'(FLUX_MIN);
        end
        return x[FW-1:0];
    endfunction

endpackage

// ===== design/shbi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbi_if
// Channel interfaces: input step request, result, configuration write.
// ----------------------------------------------------------------------------
interface shbi_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] indoor_temp;
    logic signed [15:0] outdoor_temp;
    logic signed [15:0] sky_temp;
    logic signed [16:0] sun_on_cover;
    logic signed [16:0] sun_on_screens;
    logic signed [16:0] crop_top_flux;
    logic signed [16:0] crop_middle_flux;
    logic signed [16:0] crop_bottom_flux;
    modport source (output valid, indoor_temp, outdoor_temp, sky_temp, sun_on_cover,
                    sun_on_screens, crop_top_flux, crop_middle_flux, crop_bottom_flux,
                    input ready);
    modport sink (input valid, indoor_temp, outdoor_temp, sky_temp, sun_on_cover,
                  sun_on_screens, crop_top_flux, crop_middle_flux, crop_bottom_flux,
                  output ready);
endinterface

interface shbi_out_if;
    logic valid;
    logic ready;
    logic signed [16:0] outside_to_cover;
    logic signed [16:0] inside_to_cover;
    logic signed [16:0] sky_to_cover;
    logic signed [16:0] sun_cover_out;
    logic signed [16:0] sun_screens_out;
    logic signed [15:0] cover_temp_out;
    logic signed [15:0] screen_temp_out;
    logic signed [16:0] net_flux_to_air;
    modport source (output valid, outside_to_cover, inside_to_cover, sky_to_cover,
                    sun_cover_out, sun_screens_out, cover_temp_out, screen_temp_out,
                    net_flux_to_air, input ready);
    modport sink (input valid, outside_to_cover, inside_to_cover, sky_to_cover,
                  sun_cover_out, sun_screens_out, cover_temp_out, screen_temp_out,
                  net_flux_to_air, output ready);
endinterface

interface shbi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [19:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/shbi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module shbi_div #(
    parameter int unsigned NUMW = shbi_pkg::NUMW,
    parameter int unsigned DENW = shbi_pkg::DENW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quo
);
    localparam int CW = $clog2(NUMW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [DENW-1:0] r_rem, n_rem;
    logic [DENW-1:0] r_den, n_den;
    logic [NUMW-1:0] r_quo, n_quo;
    logic [DENW:0]   w_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        w_sh   = {r_rem, r_quo[NUMW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NUMW);
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = DENW'(w_sh - {1'b0, r_den});
                n_quo = {r_quo[NUMW-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DENW-1:0];
                n_quo = {r_quo[NUMW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/shbi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbi_ctrl
// Sequencer: steps the datapath through setup, substeps and result hand-off.
// ----------------------------------------------------------------------------
module shbi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  shbi_pkg::t_sts i_sts,
    output shbi_pkg::t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_WAIT = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    shbi_pkg::t_op r_op, n_op;
    logic          r_ph, n_ph;

    function automatic shbi_pkg::t_op f_next(shbi_pkg::t_op op, logic last);
        case (op)
            shbi_pkg::OP_DN:   return shbi_pkg::OP_UC;
            shbi_pkg::OP_UC:   return shbi_pkg::OP_AC;
            shbi_pkg::OP_AC:   return shbi_pkg::OP_CAIR;
            shbi_pkg::OP_CAIR: return shbi_pkg::OP_NC;
            shbi_pkg::OP_NC:   return shbi_pkg::OP_NA;
            shbi_pkg::OP_NA:   return shbi_pkg::OP_SK1;
            shbi_pkg::OP_SK1:  return shbi_pkg::OP_SK2;
            shbi_pkg::OP_SK2:  return shbi_pkg::OP_C1;
            shbi_pkg::OP_C1:   return shbi_pkg::OP_C2;
            shbi_pkg::OP_C2:   return shbi_pkg::OP_SG;
            shbi_pkg::OP_SG:   return shbi_pkg::OP_HS;
            shbi_pkg::OP_HS:   return shbi_pkg::OP_HO;
            shbi_pkg::OP_HO:   return shbi_pkg::OP_HI;
            shbi_pkg::OP_HI:   return shbi_pkg::OP_TOT;
            shbi_pkg::OP_TOT:  return shbi_pkg::OP_TS;
            shbi_pkg::OP_TS:   return shbi_pkg::OP_DTC;
            shbi_pkg::OP_DTC:  return shbi_pkg::OP_IS;
            shbi_pkg::OP_IS:   return shbi_pkg::OP_DTI;
            shbi_pkg::OP_DTI:  return last ? shbi_pkg::OP_DNET : shbi_pkg::OP_C1;
            default:           return shbi_pkg::OP_DN;
        endcase
    endfunction

    function automatic logic f_is_div(shbi_pkg::t_op op);
        return (op == shbi_pkg::OP_DTC) || (op == shbi_pkg::OP_DTI) ||
               (op == shbi_pkg::OP_DNET);
    endfunction

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_ph       = r_ph;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = shbi_pkg::OP_DN;
                    n_state    = S_MUL;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT, S_MUL: begin
                if (r_state == S_MUL && !r_ph) begin
                    o_cmd.mul = 1'b1;
                    n_ph      = 1'b1;
                end else if (r_state == S_MUL || i_sts.div_done) begin
                    o_cmd.wb      = 1'b1;
                    o_cmd.sub_inc = (r_op == shbi_pkg::OP_DTI);
                    n_ph          = 1'b0;
                    n_op          = f_next(r_op, i_sts.last);
                    if (r_op == shbi_pkg::OP_DNET) begin
                        n_state = S_OUT;
                    end else if (f_is_div(n_op)) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= shbi_pkg::OP_DN;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_ph    <= n_ph;
        end
    end

endmodule

// ===== design/shbi_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbi_dpath
// Registers, shared multiplier, divider and result register of the integrator.
// ----------------------------------------------------------------------------
module shbi_dpath #(
    parameter int unsigned MAX_SUBSTEP_SECONDS = shbi_pkg::MAX_SUBSTEP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [shbi_pkg::CIW-1:0]      i_cfg_index,
    input  logic [shbi_pkg::CDW-1:0]      i_cfg_data,
    input  logic signed [15:0]            i_indoor_temp,
    input  logic signed [15:0]            i_outdoor_temp,
    input  logic signed [15:0]            i_sky_temp,
    input  logic signed [16:0]            i_sun_on_cover,
    input  logic signed [16:0]            i_sun_on_screens,
    input  logic signed [16:0]            i_crop_top_flux,
    input  logic signed [16:0]            i_crop_middle_flux,
    input  logic signed [16:0]            i_crop_bottom_flux,
    input  shbi_pkg::t_cmd                i_cmd,
    output shbi_pkg::t_sts                o_sts,
    shbi_out_if.source                    o_out
);
    localparam int NW   = shbi_pkg::NW;
    localparam int NUMW = shbi_pkg::NUMW;
    localparam int DENW = shbi_pkg::DENW;
    // substep count by reciprocal multiplication, exact for 12-bit steps
    localparam int unsigned RCP_SH = 24;
    localparam int unsigned RCP    = ((1 << RCP_SH) + MAX_SUBSTEP_SECONDS - 1)
                                     / MAX_SUBSTEP_SECONDS;

    logic [14:0] r_u;
    logic [16:0] r_absq;
    logic [19:0] r_capc, r_caps;
    logic [11:0] r_step;
    logic [13:0] r_hh;
    logic [11:0] r_cpg;

    logic signed [15:0] r_tc, r_ts, r_ti, r_to, r_tsky;
    logic signed [16:0] r_sunc, r_suns;
    logic signed [18:0] r_crop;

    logic [NW-1:0]      r_n, r_i;
    logic [26:0]        r_uc;
    logic [28:0]        r_ac;
    logic [24:0]        r_cair;
    logic [DENW-1:0]    r_dc, r_da;
    logic [25:0]        r_t2;
    logic [34:0]        r_sky4;
    shbi_pkg::t_diff    r_diff;
    logic signed [27:0] r_s16;
    shbi_pkg::t_flx     r_hsky, r_hout, r_hin;
    logic signed [36:0] r_acc;
    shbi_pkg::t_tot     r_tot;
    shbi_pkg::t_num     r_num;
    logic               r_neg;
    logic signed [16:0] r_net;
    shbi_pkg::t_prod    r_prod;

    logic               r_ov;
    logic signed [16:0] r_o_hout, r_o_hin, r_o_hsky, r_o_sunc, r_o_suns, r_o_net;
    logic signed [15:0] r_o_tc, r_o_ts;

    shbi_pkg::t_mula w_a;
    shbi_pkg::t_mulb w_b;
    shbi_pkg::t_prod w_p;
    shbi_pkg::t_prod w_r8, w_r16, w_r20, w_r24, w_r36;
    logic [20:0]     w_ctot;
    logic [20:0]     w_ctot1;
    shbi_pkg::t_num  w_mag;
    logic [NUMW-1:0] w_dnum;
    logic [DENW-1:0] w_dden;
    logic            w_dneg;
    logic            w_done;
    logic [NUMW-1:0] w_q;
    shbi_pkg::t_wide w_qs;
    logic signed [15:0] w_scr;

    assign w_ctot  = {1'b0, r_capc} + {1'b0, r_caps};
    assign w_ctot1 = (w_ctot == '0) ? 21'd1 : w_ctot;

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.op)
            shbi_pkg::OP_DN: begin
                w_a = shbi_pkg::t_mula'(r_step);
                w_b = shbi_pkg::t_mulb'(RCP);
            end
            shbi_pkg::OP_UC: begin
                w_a = shbi_pkg::t_mula'(r_u);
                w_b = shbi_pkg::t_mulb'(r_cpg);
            end
            shbi_pkg::OP_AC: begin
                w_a = shbi_pkg::t_mula'(r_absq);
                w_b = shbi_pkg::t_mulb'(r_cpg);
            end
            shbi_pkg::OP_CAIR: begin
                w_a = shbi_pkg::t_mula'(r_hh);
                w_b = shbi_pkg::t_mulb'(shbi_pkg::RHO_CP);
            end
            shbi_pkg::OP_NC: begin
                w_a = shbi_pkg::t_mula'(r_n);
                w_b = shbi_pkg::t_mulb'(w_ctot1);
            end
            shbi_pkg::OP_NA: begin
                w_a = shbi_pkg::t_mula'(r_n);
                w_b = shbi_pkg::t_mulb'(r_cair);
            end
            shbi_pkg::OP_SK1: begin
                w_a = shbi_pkg::t_mula'(r_tsky) + shbi_pkg::t_mula'(shbi_pkg::KELVIN_Q8);
                w_b = shbi_pkg::t_mulb'(r_tsky) + shbi_pkg::t_mulb'(shbi_pkg::KELVIN_Q8);
            end
            shbi_pkg::OP_C1: begin
                w_a = shbi_pkg::t_mula'(r_tc) + shbi_pkg::t_mula'(shbi_pkg::KELVIN_Q8);
                w_b = shbi_pkg::t_mulb'(r_tc) + shbi_pkg::t_mulb'(shbi_pkg::KELVIN_Q8);
            end
            shbi_pkg::OP_SK2, shbi_pkg::OP_C2: begin
                w_a = shbi_pkg::t_mula'(r_t2);
                w_b = shbi_pkg::t_mulb'(r_t2);
            end
            shbi_pkg::OP_SG: begin
                w_a = shbi_pkg::t_mula'(r_diff);
                w_b = shbi_pkg::t_mulb'(shbi_pkg::SIGMA_Q40);
            end
            shbi_pkg::OP_HS: begin
                w_a = shbi_pkg::t_mula'(r_s16);
                w_b = shbi_pkg::t_mulb'(r_ac);
            end
            shbi_pkg::OP_HO: begin
                w_a = shbi_pkg::t_mula'(r_to) - shbi_pkg::t_mula'(r_tc);
                w_b = shbi_pkg::t_mulb'(r_uc);
            end
            shbi_pkg::OP_HI: begin
                w_a = shbi_pkg::t_mula'(r_ti) - shbi_pkg::t_mula'(r_tc);
                w_b = shbi_pkg::t_mulb'(r_uc);
            end
            shbi_pkg::OP_TS: begin
                w_a = shbi_pkg::t_mula'(r_tot);
                w_b = shbi_pkg::t_mulb'(r_step);
            end
            shbi_pkg::OP_IS: begin
                w_a = shbi_pkg::t_mula'(r_hin);
                w_b = shbi_pkg::t_mulb'(r_step);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_p   = w_a * w_b;
    assign w_r8  = shbi_pkg::shr_rnd(r_prod, 8);
    assign w_r16 = shbi_pkg::shr_rnd(r_prod, 16);
    assign w_r20 = shbi_pkg::shr_rnd(r_prod, 20);
    assign w_r24 = shbi_pkg::shr_rnd(r_prod, 24);
    assign w_r36 = shbi_pkg::shr_rnd(r_prod, 36);
    assign w_scr = shbi_pkg::sat_temp(shbi_pkg::t_wide'(shbi_pkg::shr_rnd(
                       shbi_pkg::t_prod'(r_tc) + shbi_pkg::t_prod'(r_ti), 1)));

    always_comb begin
        w_mag  = (r_num < 0) ? -r_num : r_num;
        w_dnum = '0;
        w_dden = DENW'(1);
        w_dneg = 1'b0;
        case (i_cmd.op)
            shbi_pkg::OP_DTC: begin
                w_dnum = NUMW'(w_mag) + NUMW'(r_dc >> 1);
                w_dden = r_dc;
                w_dneg = (r_num < 0);
            end
            shbi_pkg::OP_DTI: begin
                w_dnum = NUMW'(w_mag) + NUMW'(r_da >> 1);
                w_dden = r_da;
                w_dneg = (r_num < 0);
            end
            shbi_pkg::OP_DNET: begin
                w_dnum = NUMW'((r_acc < 0) ? -r_acc : r_acc) + NUMW'(r_n >> 1);
                w_dden = DENW'(r_n);
                w_dneg = (r_acc < 0);
            end
            default: begin
                w_dnum = '0;
                w_dden = DENW'(1);
                w_dneg = 1'b0;
            end
        endcase
    end

    shbi_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_done),
        .o_quo   (w_q)
    );

    assign w_qs = r_neg ? -shbi_pkg::t_wide'({2'b00, w_q}) : shbi_pkg::t_wide'({2'b00, w_q});

    // configuration and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u    <= 15'(shbi_pkg::RST_U);
            r_absq <= 17'(shbi_pkg::RST_ABS);
            r_capc <= 20'(shbi_pkg::RST_CAPC);
            r_caps <= 20'(shbi_pkg::RST_CAPS);
            r_step <= 12'(shbi_pkg::RST_STEP);
            r_hh   <= 14'(shbi_pkg::RST_HH);
            r_cpg  <= 12'(shbi_pkg::RST_CPG);
            r_tc   <= 16'(shbi_pkg::RST_TEMP);
            r_ts   <= 16'(shbi_pkg::RST_TEMP);
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    shbi_pkg::REG_U:    r_u    <= i_cfg_data[14:0];
                    shbi_pkg::REG_ABS:  r_absq <= i_cfg_data[16:0];
                    shbi_pkg::REG_CAPC: r_capc <= i_cfg_data[19:0];
                    shbi_pkg::REG_CAPS: r_caps <= i_cfg_data[19:0];
                    shbi_pkg::REG_STEP: r_step <= i_cfg_data[11:0];
                    shbi_pkg::REG_HH:   r_hh   <= i_cfg_data[13:0];
                    shbi_pkg::REG_CPG:  r_cpg  <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.wb && i_cmd.op == shbi_pkg::OP_C1) begin
                r_ts <= w_scr;
            end
            if (i_cmd.wb && i_cmd.op == shbi_pkg::OP_DTC) begin
                r_tc <= shbi_pkg::sat_temp(shbi_pkg::t_wide'(r_tc) + w_qs);
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ti   <= i_indoor_temp;
            r_to   <= i_outdoor_temp;
            r_tsky <= i_sky_temp;
            r_sunc <= i_sun_on_cover;
            r_suns <= i_sun_on_screens;
            r_crop <= 19'(i_crop_top_flux) + 19'(i_crop_middle_flux)
                      + 19'(i_crop_bottom_flux);
            r_acc  <= '0;
            r_i    <= '0;
        end
        if (i_cmd.sub_inc) begin
            r_i <= r_i + NW'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= w_p;
        end
        if (i_cmd.div_start) begin
            r_neg <= w_dneg;
        end
        if (i_cmd.wb) begin
            case (i_cmd.op)
                shbi_pkg::OP_DN:   r_n <= (r_prod[RCP_SH+NW-1:RCP_SH] == '0) ? NW'(1)
                                          : r_prod[RCP_SH+NW-1:RCP_SH];
                shbi_pkg::OP_UC:   r_uc <= r_prod[26:0];
                shbi_pkg::OP_AC:   r_ac <= r_prod[28:0];
                shbi_pkg::OP_CAIR: r_cair <= (r_prod == '0) ? 25'd1 : r_prod[24:0];
                shbi_pkg::OP_NC:   r_dc <= r_prod[DENW-1:0];
                shbi_pkg::OP_NA:   r_da <= r_prod[DENW-1:0];
                shbi_pkg::OP_SK1, shbi_pkg::OP_C1: r_t2 <= w_r8[25:0];
                shbi_pkg::OP_SK2:  r_sky4 <= w_r16[34:0];
                shbi_pkg::OP_C2:   r_diff <= shbi_pkg::t_diff'(r_sky4)
                                             - shbi_pkg::t_diff'(w_r16[34:0]);
                shbi_pkg::OP_SG:   r_s16 <= w_r24[27:0];
                shbi_pkg::OP_HS:   r_hsky <= w_r36[24:0];
                shbi_pkg::OP_HO:   r_hout <= w_r20[24:0];
                shbi_pkg::OP_HI: begin
                    r_hin <= w_r20[24:0];
                    r_acc <= r_acc - 37'(shbi_pkg::t_flx'(w_r20[24:0]));
                end
                shbi_pkg::OP_TOT:  r_tot <= shbi_pkg::t_tot'(r_hout) + shbi_pkg::t_tot'(r_hin)
                                            + shbi_pkg::t_tot'(r_hsky)
                                            + shbi_pkg::t_tot'(r_sunc)
                                            + shbi_pkg::t_tot'(r_suns)
                                            + shbi_pkg::t_tot'(r_crop);
                shbi_pkg::OP_TS:   r_num <= shbi_pkg::t_num'(r_prod) <<< 4;
                shbi_pkg::OP_IS:   r_num <= -(shbi_pkg::t_num'(r_prod) <<< 12);
                shbi_pkg::OP_DTI:  r_ti <= shbi_pkg::sat_temp(shbi_pkg::t_wide'(r_ti) + w_qs);
                shbi_pkg::OP_DNET: r_net <= shbi_pkg::sat_flux(w_qs);
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_hout <= shbi_pkg::sat_flux(shbi_pkg::t_wide'(r_hout));
            r_o_hin  <= shbi_pkg::sat_flux(shbi_pkg::t_wide'(r_hin));
            r_o_hsky <= shbi_pkg::sat_flux(shbi_pkg::t_wide'(r_hsky));
            r_o_sunc <= r_sunc;
            r_o_suns <= r_suns;
            r_o_tc   <= r_tc;
            r_o_ts   <= r_ts;
            r_o_net  <= r_net;
        end
    end

    assign o_sts.div_done = w_done;
    assign o_sts.last     = (r_i == r_n - NW'(1));
    assign o_sts.out_free = !r_ov || o_out.ready;

    assign o_out.valid            = r_ov;
    assign o_out.outside_to_cover = r_o_hout;
    assign o_out.inside_to_cover  = r_o_hin;
    assign o_out.sky_to_cover     = r_o_hsky;
    assign o_out.sun_cover_out    = r_o_sunc;
    assign o_out.sun_screens_out  = r_o_suns;
    assign o_out.cover_temp_out   = r_o_tc;
    assign o_out.screen_temp_out  = r_o_ts;
    assign o_out.net_flux_to_air  = r_o_net;

endmodule

// ===== design/shelter_heat_balance_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelter_heat_balance_integrator
// Explicit Euler integration of cover and indoor temperature over one step.
//
//   channel  dir  handshake        payload
//   i_in     in   valid / ready    temperatures, sun and crop fluxes
//   o_out    out  valid / ready    fluxes, cover and screen temps, net flux
//   i_cfg    in   valid / ready    register index, write data
//
// A request runs n substeps, n = max(step_seconds / MAX_SUBSTEP_SECONDS, 1)
// rounded down. The divider pass is used twice per substep and once for the
// mean flux; each multiplier op is a multiply, then a write-back. Reset is
// synchronous and restores the configuration registers and the cover and
// screen temperatures. The result register frees the input side while a
// result waits; a stalled output holds the next result in the sequencer.
// ----------------------------------------------------------------------------
module shelter_heat_balance_integrator #(
    parameter int unsigned MAX_SUBSTEP_SECONDS = shbi_pkg::MAX_SUBSTEP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shbi_in_if.sink     i_in,
    shbi_out_if.source  o_out,
    shbi_cfg_if.sink    i_cfg
);
    shbi_pkg::t_cmd w_cmd;
    shbi_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    shbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    shbi_dpath #(
        .MAX_SUBSTEP_SECONDS (MAX_SUBSTEP_SECONDS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_indoor_temp      (i_in.indoor_temp),
        .i_outdoor_temp     (i_in.outdoor_temp),
        .i_sky_temp         (i_in.sky_temp),
        .i_sun_on_cover     (i_in.sun_on_cover),
        .i_sun_on_screens   (i_in.sun_on_screens),
        .i_crop_top_flux    (i_in.crop_top_flux),
        .i_crop_middle_flux (i_in.crop_middle_flux),
        .i_crop_bottom_flux (i_in.crop_bottom_flux),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_out              (o_out)
    );

endmodule
